// File: rtl/core/tesp_pkg.sv
// ----------------------------------------------------------------------------
// tesp_pkg
// Types and constants shared by the terminal escape-sequence parser.
// ----------------------------------------------------------------------------
package tesp_pkg;

   localparam int MAX_PARAMS        = 16;
   localparam int MAX_INTERMEDIATES = 2;
   localparam int MAX_OSC_BYTES     = 512;
   localparam int PIDX_W            = $clog2(MAX_PARAMS);
   localparam int PCNT_W            = $clog2(MAX_PARAMS + 1);
   localparam int IIDX_W            = (MAX_INTERMEDIATES > 1) ? $clog2(MAX_INTERMEDIATES) : 1;
   localparam int ICNT_W            = $clog2(MAX_INTERMEDIATES + 1);
   localparam int OCNT_W            = $clog2(MAX_OSC_BYTES);

   localparam logic [30:0] CLAMP_LIMIT = 31'd100000000;
   localparam logic [30:0] OMITTED     = '1;

   localparam logic [7:0] B_CAN = 8'h18;
   localparam logic [7:0] B_SUB = 8'h1A;
   localparam logic [7:0] B_ESC = 8'h1B;
   localparam logic [7:0] B_DEL = 8'h7F;
   localparam logic [7:0] B_ST  = 8'h9C;
   localparam logic [7:0] B_BEL = 8'h07;
   localparam logic [7:0] B_BSL = 8'h5C;

   typedef enum logic [3:0] {
      EV_PRINT   = 4'd0,
      EV_EXECUTE = 4'd1,
      EV_ESC     = 4'd2,
      EV_CSI     = 4'd3,
      EV_HOOK    = 4'd4,
      EV_PUT     = 4'd5,
      EV_UNHOOK  = 4'd6,
      EV_OSC_PUT = 4'd7,
      EV_OSC_END = 4'd8
   } event_type;

   typedef enum logic [1:0] {
      EL_HEADER = 2'd0,
      EL_PARAM  = 2'd1,
      EL_INTER  = 2'd2
   } element_type;

   typedef enum logic [3:0] {
      S_GROUND, S_ESC, S_ESC_INT, S_CSI_ENTRY, S_CSI_PARAM, S_CSI_INT,
      S_CSI_IGN, S_DCS_ENTRY, S_DCS_PARAM, S_DCS_INT, S_DCS_PASS, S_DCS_IGN,
      S_OSC, S_SOS
   } parse_type;

   // sequencer phases
   typedef enum logic [2:0] {
      PH_IDLE, PH_DIGIT, PH_HEADER, PH_PARAMS, PH_INTERS
   } phase_type;

   typedef struct packed {
      event_type   kind;
      element_type elem;
      logic [7:0]  byte_value;
      logic [30:0] param_value;
      logic [7:0]  marker;
      logic [4:0]  pcount;
      logic [1:0]  icount;
      logic [8:0]  slen;
      logic        last;
   } result_type;

endpackage

// File: rtl/core/terminal_escape_sequence_parser.sv
// ----------------------------------------------------------------------------
// terminal_escape_sequence_parser
// VT/ANSI escape-sequence automaton with parameter memory and dispatch runs.
// ----------------------------------------------------------------------------
// Usage: one terminal byte per item enters on req_ (tdata = in_byte). Results
// leave on rsp_, one event per item; rsp_tlast marks the final result caused
// by one input byte. Bytes that cause no result produce nothing.
// Parameters live in a 16-entry synchronous RAM with a registered read port.
// A digit that extends an open parameter is a read-modify-write (read, then
// multiply-add and write back); a parameter's first digit is written directly.
// Other bytes emit at most one result, except those that start a dispatch run.
// A dispatch run holds input and emits the header, parameters, intermediates,
// one per cycle while output has space; each read is issued an element ahead.
// The output register accepts its next result while the previous is taken,
// so a stalled receiver stops the parser only when the register is full.
// Reset (synchronous, active high) returns to ground with empty collections;
// parameters are written before use, so the RAM needs no clearing.
// ----------------------------------------------------------------------------
module terminal_escape_sequence_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] in_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,    // event_kind[3:0], element_kind[5:4],
                                     // byte_value[13:6], param_value[44:14],
                                     // marker_byte[52:45], param_count[57:53],
                                     // inter_count[59:58], string_length[68:60]
   output logic        rsp_tlast     // last
);

   // parameter memory
   logic [30:0] pmem [tesp_pkg::MAX_PARAMS];
   logic [30:0] prd_ff;
   logic        pwe;
   logic [tesp_pkg::PIDX_W-1:0] pwa, pra;
   logic [30:0] pwd;

   always_ff @(posedge clock) begin
      if (pwe) pmem[pwa] <= pwd;
      prd_ff <= pmem[pra];
   end

   tesp_pkg::parse_type state_ff, state_in, origin_ff, origin_in;
   tesp_pkg::phase_type phase_ff, phase_in;
   logic [tesp_pkg::PCNT_W-1:0] ptot_ff, ptot_in;
   logic popen_ff, popen_in, povf_ff, povf_in;
   logic [7:0] inter_ff [tesp_pkg::MAX_INTERMEDIATES];
   logic [7:0] inter_in [tesp_pkg::MAX_INTERMEDIATES];
   logic [tesp_pkg::ICNT_W-1:0] itot_ff, itot_in;
   logic iovf_ff, iovf_in;
   logic [7:0] mark_ff, mark_in;
   logic [tesp_pkg::OCNT_W-1:0] ocnt_ff, ocnt_in;
   logic oovf_ff, oovf_in;
   // run bookkeeping
   tesp_pkg::event_type rkind_ff, rkind_in;
   logic [7:0] rfin_ff, rfin_in, dig_ff, dig_in;
   logic rwp_ff, rwp_in;
   logic [tesp_pkg::PCNT_W-1:0] ridx_ff, ridx_in;
   logic [tesp_pkg::ICNT_W-1:0] iidx_ff, iidx_in;

   tesp_pkg::result_type out_ff, out_in, res;
   logic ovalid_ff, ovalid_in, emit;

   logic space, take;
   assign space = !ovalid_ff || rsp_tready;
   assign take  = req_tvalid && req_tready;
   assign req_tready = (phase_ff == tesp_pkg::PH_IDLE) && space;

   logic [tesp_pkg::PCNT_W-1:0] pc_run;
   assign pc_run = rwp_ff ? ptot_ff : '0;

   always_comb begin
      logic [7:0] b;
      logic is_int, is_dig, is_fin, is_sep, is_mrk, csi, dcs;
      logic [1:0] ph;
      logic [34:0] prod;
      b = req_tdata;
      state_in = state_ff; origin_in = origin_ff; phase_in = phase_ff;
      ptot_in = ptot_ff; popen_in = popen_ff; povf_in = povf_ff;
      inter_in = inter_ff; itot_in = itot_ff; iovf_in = iovf_ff;
      mark_in = mark_ff; ocnt_in = ocnt_ff; oovf_in = oovf_ff;
      rkind_in = rkind_ff; rfin_in = rfin_ff; rwp_in = rwp_ff;
      ridx_in = ridx_ff; iidx_in = iidx_ff; dig_in = dig_ff;
      pwe = 1'b0; pwa = ptot_ff[tesp_pkg::PIDX_W-1:0]; pwd = '0;
      pra = ptot_ff[tesp_pkg::PIDX_W-1:0];
      res = '0; emit = 1'b0;
      prod = '0;
      is_int = b >= 8'h20 && b <= 8'h2F;
      is_dig = b >= 8'h30 && b <= 8'h39;
      is_fin = b >= 8'h40 && b <= 8'h7E;
      is_sep = b == 8'h3A || b == 8'h3B;
      is_mrk = b >= 8'h3C && b <= 8'h3F;
      csi = state_ff == tesp_pkg::S_CSI_ENTRY || state_ff == tesp_pkg::S_CSI_PARAM
         || state_ff == tesp_pkg::S_CSI_INT;
      dcs = state_ff == tesp_pkg::S_DCS_ENTRY || state_ff == tesp_pkg::S_DCS_PARAM
         || state_ff == tesp_pkg::S_DCS_INT;
      ph = (state_ff == tesp_pkg::S_CSI_ENTRY || state_ff == tesp_pkg::S_DCS_ENTRY)
         ? 2'd0 : (state_ff == tesp_pkg::S_CSI_PARAM
         || state_ff == tesp_pkg::S_DCS_PARAM) ? 2'd1 : 2'd2;

      unique case (phase_ff)
         tesp_pkg::PH_DIGIT: begin
            // prd_ff holds the open parameter; multiply-add and write back
            pwa = ptot_ff[tesp_pkg::PIDX_W-1:0] - 1'b1;
            prod = {4'd0, prd_ff} * 35'd10 + {31'd0, dig_ff[3:0]};
            pwd = prod[30:0];
            pwe = prd_ff < tesp_pkg::CLAMP_LIMIT;
            phase_in = tesp_pkg::PH_IDLE;
         end
         tesp_pkg::PH_HEADER, tesp_pkg::PH_PARAMS, tesp_pkg::PH_INTERS: begin
            pra = ridx_ff[tesp_pkg::PIDX_W-1:0];
            if (space) begin
               emit = 1'b1;
               res.kind = rkind_ff;
               if (phase_ff == tesp_pkg::PH_HEADER) begin
                  res.elem = tesp_pkg::EL_HEADER;
                  res.byte_value = rfin_ff;
                  res.marker = rwp_ff ? mark_ff : 8'd0;
                  res.pcount = 5'(pc_run);
                  res.icount = 2'(itot_ff);
               end else if (phase_ff == tesp_pkg::PH_PARAMS) begin
                  res.elem = tesp_pkg::EL_PARAM;
                  res.param_value = prd_ff;
               end else begin
                  res.elem = tesp_pkg::EL_INTER;
                  res.byte_value = inter_ff[iidx_ff[tesp_pkg::IIDX_W-1:0]];
               end
               // next element
               if (phase_ff == tesp_pkg::PH_INTERS) iidx_in = iidx_ff + 1'b1;
               else if (phase_ff == tesp_pkg::PH_PARAMS) ridx_in = ridx_ff + 1'b1;
               priority if (phase_ff != tesp_pkg::PH_INTERS
                  && ridx_in < pc_run) begin
                  phase_in = tesp_pkg::PH_PARAMS;
                  pra = ridx_in[tesp_pkg::PIDX_W-1:0];
               end else if (iidx_in < itot_ff) begin
                  phase_in = tesp_pkg::PH_INTERS;
               end else begin
                  phase_in = tesp_pkg::PH_IDLE;
               end
               res.last = phase_in == tesp_pkg::PH_IDLE;
               if (phase_in == tesp_pkg::PH_IDLE && rkind_ff == tesp_pkg::EV_CSI)
                  state_in = tesp_pkg::S_GROUND;
            end
         end
         default: begin
            if (take) begin
               res.last = 1'b1;
               res.byte_value = b;
               priority if (b == tesp_pkg::B_CAN || b == tesp_pkg::B_SUB) begin
                  state_in = tesp_pkg::S_GROUND;
                  emit = 1'b1; res.kind = tesp_pkg::EV_EXECUTE;
               end else if (b == tesp_pkg::B_ESC) begin
                  origin_in = (state_ff == tesp_pkg::S_OSC
                     || state_ff == tesp_pkg::S_DCS_PASS
                     || state_ff == tesp_pkg::S_DCS_IGN
                     || state_ff == tesp_pkg::S_SOS) ? state_ff : tesp_pkg::S_GROUND;
                  ptot_in = '0; popen_in = 1'b0; povf_in = 1'b0;
                  itot_in = '0; iovf_in = 1'b0; mark_in = '0;
                  state_in = tesp_pkg::S_ESC;
               end else if (state_ff == tesp_pkg::S_GROUND) begin
                  emit = 1'b1;
                  res.kind = b <= 8'h1F ? tesp_pkg::EV_EXECUTE : tesp_pkg::EV_PRINT;
               end else if (state_ff == tesp_pkg::S_ESC
                  || state_ff == tesp_pkg::S_ESC_INT) begin
                  priority if (b <= 8'h1F) begin
                     emit = 1'b1; res.kind = tesp_pkg::EV_EXECUTE;
                  end else if (b == tesp_pkg::B_DEL) begin
                  end else if (state_ff == tesp_pkg::S_ESC && b == tesp_pkg::B_BSL
                     && origin_ff != tesp_pkg::S_GROUND) begin
                     res.byte_value = '0;
                     if (origin_ff == tesp_pkg::S_OSC) begin
                        emit = 1'b1; res.kind = tesp_pkg::EV_OSC_END;
                        res.slen = 9'(ocnt_ff);
                     end else if (origin_ff == tesp_pkg::S_DCS_PASS) begin
                        emit = 1'b1; res.kind = tesp_pkg::EV_UNHOOK;
                     end
                     origin_in = tesp_pkg::S_GROUND;
                     state_in = tesp_pkg::S_GROUND;
                  end else begin
                     if (state_ff == tesp_pkg::S_ESC) origin_in = tesp_pkg::S_GROUND;
                     priority if (is_int) begin
                        if (itot_ff >= tesp_pkg::ICNT_W'(tesp_pkg::MAX_INTERMEDIATES))
                           iovf_in = 1'b1;
                        else begin
                           inter_in[itot_ff[tesp_pkg::IIDX_W-1:0]] = b;
                           itot_in = itot_ff + 1'b1;
                        end
                        state_in = tesp_pkg::S_ESC_INT;
                     end else if (state_ff == tesp_pkg::S_ESC && b == 8'h5B)
                        state_in = tesp_pkg::S_CSI_ENTRY;
                     else if (state_ff == tesp_pkg::S_ESC && b == 8'h5D) begin
                        ocnt_in = '0; oovf_in = 1'b0; state_in = tesp_pkg::S_OSC;
                     end else if (state_ff == tesp_pkg::S_ESC && b == 8'h50)
                        state_in = tesp_pkg::S_DCS_ENTRY;
                     else if (state_ff == tesp_pkg::S_ESC
                        && (b == 8'h58 || b == 8'h5E || b == 8'h5F))
                        state_in = tesp_pkg::S_SOS;
                     else if (b >= 8'h30 && b <= 8'h7E) begin
                        rkind_in = tesp_pkg::EV_ESC; rfin_in = b; rwp_in = 1'b0;
                        ridx_in = '0; iidx_in = '0;
                        phase_in = tesp_pkg::PH_HEADER;
                        state_in = tesp_pkg::S_GROUND;
                     end
                  end
               end else if (csi || dcs) begin
                  priority if (b <= 8'h1F) begin
                     if (csi) begin
                        emit = 1'b1; res.kind = tesp_pkg::EV_EXECUTE;
                     end
                  end else if (b == tesp_pkg::B_DEL) begin
                  end else if (ph == 2'd2 && is_int) begin
                     if (itot_ff >= tesp_pkg::ICNT_W'(tesp_pkg::MAX_INTERMEDIATES))
                        iovf_in = 1'b1;
                     else begin
                        inter_in[itot_ff[tesp_pkg::IIDX_W-1:0]] = b;
                        itot_in = itot_ff + 1'b1;
                     end
                  end else if (ph == 2'd2 && b >= 8'h30 && b <= 8'h3F) begin
                     state_in = csi ? tesp_pkg::S_CSI_IGN : tesp_pkg::S_DCS_IGN;
                  end else if (ph != 2'd2 && is_dig) begin
                     state_in = csi ? tesp_pkg::S_CSI_PARAM : tesp_pkg::S_DCS_PARAM;
                     if (!povf_ff) begin
                        if (!popen_ff) begin
                           if (ptot_ff >= tesp_pkg::PCNT_W'(tesp_pkg::MAX_PARAMS))
                              povf_in = 1'b1;
                           else begin
                              // new parameter opens at the digit's value
                              pwe = 1'b1; pwd = {27'd0, b[3:0]};
                              ptot_in = ptot_ff + 1'b1; popen_in = 1'b1;
                           end
                        end else begin
                           pra = ptot_ff[tesp_pkg::PIDX_W-1:0] - 1'b1;
                           dig_in = b;
                           phase_in = tesp_pkg::PH_DIGIT;
                        end
                     end
                  end else if (ph != 2'd2 && is_sep) begin
                     state_in = csi ? tesp_pkg::S_CSI_PARAM : tesp_pkg::S_DCS_PARAM;
                     if (!povf_ff) begin
                        if (ptot_ff >= tesp_pkg::PCNT_W'(tesp_pkg::MAX_PARAMS))
                           povf_in = 1'b1;
                        else begin
                           if (!popen_ff) begin
                              pwe = 1'b1; pwd = tesp_pkg::OMITTED;
                              ptot_in = ptot_ff + 1'b1;
                           end
                           popen_in = 1'b0;
                        end
                     end
                  end else if (ph != 2'd2 && is_mrk) begin
                     if (ph == 2'd0) begin
                        mark_in = b;
                        state_in = csi ? tesp_pkg::S_CSI_PARAM : tesp_pkg::S_DCS_PARAM;
                     end else
                        state_in = csi ? tesp_pkg::S_CSI_IGN : tesp_pkg::S_DCS_IGN;
                  end else if (ph != 2'd2 && is_int) begin
                     if (itot_ff >= tesp_pkg::ICNT_W'(tesp_pkg::MAX_INTERMEDIATES))
                        iovf_in = 1'b1;
                     else begin
                        inter_in[itot_ff[tesp_pkg::IIDX_W-1:0]] = b;
                        itot_in = itot_ff + 1'b1;
                     end
                     state_in = csi ? tesp_pkg::S_CSI_INT : tesp_pkg::S_DCS_INT;
                  end else if (is_fin) begin
                     if (csi) begin
                        state_in = tesp_pkg::S_GROUND;
                        if (!povf_ff && !iovf_ff) begin
                           // ground is set when the run ends
                           state_in = state_ff;
                           rkind_in = tesp_pkg::EV_CSI; rfin_in = b; rwp_in = 1'b1;
                           ridx_in = '0; iidx_in = '0;
                           phase_in = tesp_pkg::PH_HEADER;
                        end
                     end else begin
                        rkind_in = tesp_pkg::EV_HOOK; rfin_in = b; rwp_in = 1'b1;
                        ridx_in = '0; iidx_in = '0;
                        phase_in = tesp_pkg::PH_HEADER;
                        state_in = tesp_pkg::S_DCS_PASS;
                     end
                  end else begin
                     state_in = csi ? tesp_pkg::S_CSI_IGN : tesp_pkg::S_DCS_IGN;
                  end
               end else if (state_ff == tesp_pkg::S_CSI_IGN) begin
                  if (b <= 8'h1F) begin
                     emit = 1'b1; res.kind = tesp_pkg::EV_EXECUTE;
                  end else if (is_fin) state_in = tesp_pkg::S_GROUND;
               end else if (state_ff == tesp_pkg::S_DCS_PASS) begin
                  if (b == tesp_pkg::B_ST) begin
                     emit = 1'b1; res.kind = tesp_pkg::EV_UNHOOK; res.byte_value = '0;
                     state_in = tesp_pkg::S_GROUND;
                  end else if (b != tesp_pkg::B_DEL) begin
                     emit = 1'b1; res.kind = tesp_pkg::EV_PUT;
                  end
               end else if (state_ff == tesp_pkg::S_OSC) begin
                  if (b == tesp_pkg::B_BEL || b == tesp_pkg::B_ST) begin
                     emit = 1'b1; res.kind = tesp_pkg::EV_OSC_END; res.byte_value = '0;
                     res.slen = 9'(ocnt_ff);
                     state_in = tesp_pkg::S_GROUND;
                  end else if (b > 8'h1F && !oovf_ff) begin
                     if ({1'b0, ocnt_ff} + 1'b1 >=
                        (tesp_pkg::OCNT_W+1)'(tesp_pkg::MAX_OSC_BYTES))
                        oovf_in = 1'b1;
                     else begin
                        ocnt_in = ocnt_ff + 1'b1;
                        emit = 1'b1; res.kind = tesp_pkg::EV_OSC_PUT;
                     end
                  end
               end else begin
                  if (b == tesp_pkg::B_ST) state_in = tesp_pkg::S_GROUND;
               end
               // a dispatch header goes out in its own cycle
               if (phase_in == tesp_pkg::PH_HEADER) emit = 1'b0;
               if (phase_in == tesp_pkg::PH_HEADER && rkind_in != tesp_pkg::EV_ESC)
                  rwp_in = 1'b1;
            end
         end
      endcase
      out_in = emit ? res : out_ff;
      ovalid_in = emit || (ovalid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tesp_pkg::S_GROUND; origin_ff <= tesp_pkg::S_GROUND;
         phase_ff <= tesp_pkg::PH_IDLE;
         ptot_ff <= '0; popen_ff <= 1'b0; povf_ff <= 1'b0;
         itot_ff <= '0; iovf_ff <= 1'b0; mark_ff <= '0;
         ocnt_ff <= '0; oovf_ff <= 1'b0; ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; origin_ff <= origin_in; phase_ff <= phase_in;
         ptot_ff <= ptot_in; popen_ff <= popen_in; povf_ff <= povf_in;
         itot_ff <= itot_in; iovf_ff <= iovf_in; mark_ff <= mark_in;
         ocnt_ff <= ocnt_in; oovf_ff <= oovf_in; ovalid_ff <= ovalid_in;
      end
      inter_ff <= inter_in; rkind_ff <= rkind_in; rfin_ff <= rfin_in;
      rwp_ff <= rwp_in; ridx_ff <= ridx_in; iidx_ff <= iidx_in; dig_ff <= dig_in;
      out_ff <= out_in;
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tlast  = out_ff.last;
   assign rsp_tdata  = {3'd0, out_ff.slen, out_ff.icount, out_ff.pcount, out_ff.marker,
                        out_ff.param_value, out_ff.byte_value, out_ff.elem, out_ff.kind};

endmodule
